// ===== design/abv_pkg.sv =====
// Package for the animated bounded value block: request and result types,
// operation codes, register indexes and fixed constants.
// Used by abv_div and animated_bounded_value.
`timescale 1ns / 1ps
`default_nettype none

package abv_pkg;

    // Width of the divisor and remainder of the shared divider.
    localparam int DVS_W = 33;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    // Half pi with 30 fraction bits.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_MODIFY = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [2:0] CFG_MIN_VALUE      = 3'd0;
    localparam logic [2:0] CFG_MAX_VALUE      = 3'd1;
    localparam logic [2:0] CFG_WRAP_ENABLE    = 3'd2;
    localparam logic [2:0] CFG_RAMP_DELTA     = 3'd3;
    localparam logic [2:0] CFG_RAMP_PERIOD_MS = 3'd4;
    localparam logic [2:0] CFG_WAVE_AMPLITUDE = 3'd5;
    localparam logic [2:0] CFG_WAVE_PERIOD_MS = 3'd6;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] operand;
        logic [31:0]        time_ms;
    } abv_req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               notify;
        logic signed [31:0] notify_value;
    } abv_rsp_t;

endpackage

`default_nettype wire

// ===== design/abv_div.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned.
// A narrow request divides a DVS_W-bit dividend, a wide one a DIV_W-bit dividend.
// Depends on abv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abv_div #(
    parameter int DIV_W = 45
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       wide,
    input  wire logic [DIV_W-1:0]           dividend,
    input  wire logic [abv_pkg::DVS_W-1:0]  divisor,
    output logic                            done,
    output logic [DIV_W-1:0]                quotient,
    output logic [abv_pkg::DVS_W-1:0]       remainder
);
    import abv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, q_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            // A narrow dividend is moved to the top so that the same shift works.
            q_next   = wide ? dividend : (dividend << (DIV_W - DVS_W));
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = wide ? CNT_W'(DIV_W) : CNT_W'(DVS_W);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[DVS_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/animated_bounded_value.sv =====
// Top level of the animated bounded value block: sequencer, shared multiplier,
// sine quarter table and configuration registers. Depends on abv_pkg and abv_div.
//
// A request is taken when start is high and busy is low; busy then stays high until
// the single result is shown on result for one cycle with done high. The receiver
// cannot hold a result off, so it must take it in that cycle. Done rises in the same
// cycle that busy falls. Each use of the shared divider passes a go state and a wait
// state, and the sine index uses a wide division. A ramp costs one division and a
// multiply, a wobble two divisions, two multiplies, a table lookup and an add, a
// wrapped bound one division and a compare, and a modify bounds twice. A read with
// no drift and nothing to bound goes from idle to the bound check and ends there.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while busy is low, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module animated_bounded_value #(
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int SINE_FRACTION_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire abv_pkg::abv_req_t request,
    output logic                   done,
    output abv_pkg::abv_rsp_t      result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import abv_pkg::*;

    localparam int F      = SINE_FRACTION_BITS;
    localparam int QUARTER = SINE_TABLE_ENTRIES / 4;
    localparam int FULL   = 4 * QUARTER;
    localparam int IDX_W  = $clog2(FULL);
    localparam int QA_W   = $clog2(QUARTER + 1);
    localparam int DIV_W  = 31 + IDX_W;
    localparam int ACC_W  = F + 34;
    localparam int PROD_W = 66;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_RMUL = 15'b000000000000010,
        S_RGO  = 15'b000000000000100,
        S_RDIV = 15'b000000000001000,
        S_WGO  = 15'b000000000010000,
        S_WDIV = 15'b000000000100000,
        S_WMUL = 15'b000000001000000,
        S_IGO  = 15'b000000010000000,
        S_IDIV = 15'b000000100000000,
        S_WLUT = 15'b000001000000000,
        S_WAMP = 15'b000010000000000,
        S_WADD = 15'b000100000000000,
        S_BND  = 15'b001000000000000,
        S_BGO  = 15'b010000000000000,
        S_BDIV = 15'b100000000000000
    } state_t;

    // Multiplies the series term by x twice, each product rescaled to 30 fraction bits.
    function automatic longint unsigned sq_step(input longint unsigned t,
                                                input longint unsigned x);
        longint unsigned u;
        u = (t * x) >> 30;
        return (u * x) >> 30;
    endfunction

    // Quarter-wave sine sample k, worked out at elaboration by a Taylor series.
    function automatic logic [F:0] sine_entry(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          s;
        x    = (HALF_PI_Q30 * longint'(k)) / QUARTER;
        term = x;
        sum  = longint'(x);
        term = sq_step(term, x) / 6;   sum = sum - longint'(term);
        term = sq_step(term, x) / 20;  sum = sum + longint'(term);
        term = sq_step(term, x) / 42;  sum = sum - longint'(term);
        term = sq_step(term, x) / 72;  sum = sum + longint'(term);
        term = sq_step(term, x) / 110; sum = sum - longint'(term);
        term = sq_step(term, x) / 156; sum = sum + longint'(term);
        term = sq_step(term, x) / 210; sum = sum - longint'(term);
        term = sq_step(term, x) / 272; sum = sum + longint'(term);
        term = sq_step(term, x) / 342; sum = sum - longint'(term);
        term = sq_step(term, x) / 420; sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        s = (sum + (longint'(1) <<< (29 - F))) >>> (30 - F);
        if (s > (longint'(1) <<< F))
        begin
            s = longint'(1) <<< F;
        end
        return s[F:0];
    endfunction

    logic [F:0] sine_rom [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    // Configuration registers.
    logic [31:0] min_reg, max_reg, delta_reg, amp_reg;
    logic [30:0] rper_reg, wper_reg;
    logic        wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= INT_MIN;
            max_reg   <= INT_MAX;
            wrap_reg  <= 1'b1;
            delta_reg <= '0;
            rper_reg  <= '0;
            amp_reg   <= '0;
            wper_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_VALUE:      min_reg   <= cfg_data;
                CFG_MAX_VALUE:      max_reg   <= cfg_data;
                CFG_WRAP_ENABLE:    wrap_reg  <= cfg_data[0];
                CFG_RAMP_DELTA:     delta_reg <= cfg_data;
                CFG_RAMP_PERIOD_MS: rper_reg  <= cfg_data[30:0];
                CFG_WAVE_AMPLITUDE: amp_reg   <= cfg_data;
                CFG_WAVE_PERIOD_MS: wper_reg  <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    state_t               state_reg, state_next;
    logic [31:0]          base_reg, base_next;
    logic [31:0]          stamp_reg, stamp_next;
    logic [31:0]          value_reg, value_next;
    logic [31:0]          elapsed_reg, elapsed_next;
    logic [31:0]          time_reg, time_next;
    logic [31:0]          operand_reg, operand_next;
    logic [31:0]          nv_reg, nv_next;
    logic [1:0]           func_reg, func_next;
    logic                 final_reg, final_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [30:0]          phase_reg, phase_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic signed [F+1:0]  sine_reg, sine_next;
    logic [DVS_W-1:0]     mag_reg, mag_next;
    logic [DVS_W-1:0]     range_reg, range_next;
    logic                 lo_reg, lo_next;
    logic                 done_reg, done_next;
    abv_rsp_t             rsp_reg, rsp_next;

    logic                 div_start, div_wide, div_done;
    logic [DIV_W-1:0]     div_dividend, div_quotient;
    logic [DVS_W-1:0]     div_divisor, div_rem;

    logic signed [32:0]   mul_a, mul_b;

    abv_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .wide      (div_wide),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_rem)
    );

    logic ramp_on, wave_on;
    assign ramp_on = (delta_reg != '0) && (rper_reg != '0);
    assign wave_on = (amp_reg != '0) && (wper_reg != '0);

    // Divider operands and the shared multiplier's inputs, chosen by state.
    logic [32:0] abs_prod, abs_elapsed;
    assign abs_prod    = prod_reg[31] ? 33'(-{1'b1, prod_reg[31:0]}) : {1'b0, prod_reg[31:0]};
    assign abs_elapsed = elapsed_reg[31] ? 33'(-{1'b1, elapsed_reg}) : {1'b0, elapsed_reg};

    always_comb
    begin
        div_start    = 1'b0;
        div_wide     = 1'b0;
        div_dividend = DIV_W'(mag_reg);
        div_divisor  = range_reg;
        case (state_reg)
            S_RGO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(abs_prod);
                div_divisor  = {2'b00, rper_reg};
            end
            S_WGO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(abs_elapsed);
                div_divisor  = {2'b00, wper_reg};
            end
            S_IGO:
            begin
                div_start    = 1'b1;
                div_wide     = 1'b1;
                div_dividend = prod_reg[DIV_W-1:0];
                div_divisor  = {2'b00, wper_reg};
            end
            S_BGO:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_WMUL:
            begin
                mul_a = $signed({2'b00, phase_reg});
                mul_b = 33'sd0 + 33'(FULL);
            end
            S_WAMP:
            begin
                mul_a = $signed({amp_reg[31], amp_reg});
                mul_b = 33'(sine_reg);
            end
            default:
            begin
                mul_a = $signed({delta_reg[31], delta_reg});
                mul_b = $signed({elapsed_reg[31], elapsed_reg});
            end
        endcase
    end

    // Sine lookup from the full-cycle index through quarter symmetry.
    logic [1:0]       quad;
    logic [IDX_W-1:0] rest;
    logic [QA_W-1:0]  rom_addr;
    logic [F:0]       rom_data;

    always_comb
    begin
        if (idx_reg >= IDX_W'(3 * QUARTER))
        begin
            quad = 2'd3;
            rest = idx_reg - IDX_W'(3 * QUARTER);
        end
        else if (idx_reg >= IDX_W'(2 * QUARTER))
        begin
            quad = 2'd2;
            rest = idx_reg - IDX_W'(2 * QUARTER);
        end
        else if (idx_reg >= IDX_W'(QUARTER))
        begin
            quad = 2'd1;
            rest = idx_reg - IDX_W'(QUARTER);
        end
        else
        begin
            quad = 2'd0;
            rest = idx_reg;
        end
        rom_addr = quad[0] ? QA_W'(IDX_W'(QUARTER) - rest) : QA_W'(rest);
        rom_data = sine_rom[rom_addr];
    end

    // Bound evaluation and the main sequencer.
    logic              pass_thru, lo_hit, hi_hit;
    logic signed [33:0] diff34, span34;
    logic [32:0]       wrap_m;
    logic [31:0]       quo32;
    logic [31:0]       fin_v;
    logic              fin;
    logic signed [ACC_W-1:0] acc, acc_adj;
    logic [30:0]       phase_c;

    always_comb
    begin
        pass_thru = $signed(min_reg) > $signed(max_reg);
        lo_hit    = (min_reg != INT_MIN) && ($signed(value_reg) < $signed(min_reg));
        hi_hit    = (max_reg != INT_MAX) && ($signed(value_reg) > $signed(max_reg));
        diff34    = 34'($signed(value_reg)) - 34'($signed(min_reg));
        span34    = 34'($signed(max_reg)) - 34'($signed(min_reg)) + 34'sd1;
        wrap_m    = (div_rem == '0) ? '0 : (range_reg - div_rem);
        quo32     = div_quotient[31:0];
        acc       = (ACC_W'($signed(value_reg)) <<< F) + $signed(prod_reg[ACC_W-1:0]);
        acc_adj   = acc[ACC_W-1] ? (acc + ACC_W'((1 << F) - 1)) : acc;
        phase_c   = (elapsed_reg[31] && (div_rem != '0))
                    ? 31'({2'b00, wper_reg} - div_rem) : div_rem[30:0];

        state_next   = state_reg;
        base_next    = base_reg;
        stamp_next   = stamp_reg;
        value_next   = value_reg;
        elapsed_next = elapsed_reg;
        time_next    = time_reg;
        operand_next = operand_reg;
        nv_next      = nv_reg;
        func_next    = func_reg;
        final_next   = final_reg;
        prod_next    = prod_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        sine_next    = sine_reg;
        mag_next     = mag_reg;
        range_next   = range_reg;
        lo_next      = lo_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        fin          = 1'b0;
        fin_v        = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next    = request.func;
                    operand_next = request.operand;
                    time_next    = request.time_ms;
                    elapsed_next = request.time_ms - stamp_reg;
                    if (request.func == FUNC_SET)
                    begin
                        value_next = request.operand;
                        nv_next    = request.operand;
                        final_next = 1'b1;
                        state_next = S_BND;
                    end
                    else
                    begin
                        value_next = base_reg;
                        final_next = (request.func != FUNC_MODIFY);
                        state_next = ramp_on ? S_RMUL : (wave_on ? S_WGO : S_BND);
                    end
                end
            end
            S_RMUL:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_RGO;
            end
            S_RGO:
            begin
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    value_next = value_reg + (prod_reg[31] ? (32'd0 - quo32) : quo32);
                    state_next = wave_on ? S_WGO : S_BND;
                end
            end
            S_WGO:
            begin
                state_next = S_WDIV;
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    phase_next = phase_c;
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_IGO;
            end
            S_IGO:
            begin
                state_next = S_IDIV;
            end
            S_IDIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_quotient[IDX_W-1:0];
                    state_next = S_WLUT;
                end
            end
            S_WLUT:
            begin
                sine_next  = quad[1] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
                state_next = S_WAMP;
            end
            S_WAMP:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_WADD;
            end
            S_WADD:
            begin
                value_next = acc_adj[F+31:F];
                state_next = S_BND;
            end
            S_BND:
            begin
                if (pass_thru || !(lo_hit || hi_hit))
                begin
                    fin = 1'b1;
                end
                else if (!wrap_reg)
                begin
                    fin   = 1'b1;
                    fin_v = lo_hit ? min_reg : max_reg;
                end
                else
                begin
                    lo_next    = lo_hit;
                    mag_next   = lo_hit ? 33'(-diff34) : diff34[32:0];
                    range_next = span34[32:0];
                    state_next = S_BGO;
                end
            end
            S_BGO:
            begin
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                if (div_done)
                begin
                    fin   = 1'b1;
                    fin_v = min_reg + (lo_reg ? wrap_m[31:0] : div_rem[31:0]);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (!final_reg)
            begin
                // A modify adds the delta to the bounded value and bounds once more.
                value_next = fin_v + operand_reg;
                nv_next    = fin_v + operand_reg;
                final_next = 1'b1;
                state_next = S_BND;
            end
            else
            begin
                value_next         = fin_v;
                done_next          = 1'b1;
                rsp_next.value_out = fin_v;
                state_next         = S_IDLE;
                if ((func_reg == FUNC_SET) || (func_reg == FUNC_MODIFY))
                begin
                    base_next             = fin_v;
                    stamp_next            = time_reg;
                    rsp_next.notify       = 1'b1;
                    rsp_next.notify_value = nv_reg;
                end
                else
                begin
                    rsp_next.notify       = 1'b0;
                    rsp_next.notify_value = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            stamp_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            stamp_reg <= stamp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        elapsed_reg <= elapsed_next;
        time_reg    <= time_next;
        operand_reg <= operand_next;
        nv_reg      <= nv_next;
        func_reg    <= func_next;
        final_reg   <= final_next;
        prod_reg    <= prod_next;
        phase_reg   <= phase_next;
        idx_reg     <= idx_next;
        sine_reg    <= sine_next;
        mag_reg     <= mag_next;
        range_reg   <= range_next;
        lo_reg      <= lo_next;
        rsp_reg     <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire
